// ===== sv/rdu_pkg.sv =====
// Shared types and constants for the refraction direction pipeline.
package rdu_pkg;

	localparam int IFRAC = 20;
	localparam int IONE = 1 << IFRAC;
	localparam int AW = 22;
	localparam int ETA_W = 25;
	localparam logic [ETA_W-1:0] ETA_MAX = ETA_W'(16 << IFRAC);
	localparam int EA_W = 28;
	localparam int ETAC_W = 30;
	localparam int R_W = 32;
	localparam int RAD1_W = 56;
	localparam int ROOT1_W = RAD1_W / 2;
	localparam int MAGSQ_W = 62;
	localparam int MAG_W = MAGSQ_W / 2;
	localparam int IDX_W = 16;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic [2:0][AW-1:0] a;
		logic [2:0][AW-1:0] n;
		logic ovf;
	} eta_side_t;

	typedef struct packed {
		logic [ETAC_W-1:0] etac;
		logic [2:0][AW-1:0] n;
		logic [2:0][EA_W-1:0] ea;
		logic tir;
	} root_side_t;

	typedef struct packed {
		logic [2:0][R_W-1:0] r;
		logic zero;
		logic tir;
	} mag_side_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic tir;
	} lane_side_t;

endpackage

// ===== sv/rdu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side word.
module rdu_div #(
	parameter int DW = 36,
	parameter int VW = 16,
	parameter int QW = 25,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rdu_pkg::pipe_ctl_t ctl,
	input  logic [DW-1:0]     dividend,
	input  logic [VW-1:0]     divisor,
	input  logic [SW-1:0]     side_in,
	output logic              out_vld,
	output logic [QW-1:0]     quotient,
	output logic [SW-1:0]     side_out
);
	import rdu_pkg::*;

	logic          vld_s  [QW];
	logic [VW-1:0] rem_s  [QW];
	logic [VW-1:0] dvs_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic          pv;
		logic [VW-1:0] prem;
		logic [VW-1:0] pdvs;
		logic [QW-1:0] plow;
		logic [QW-1:0] pquo;
		logic [SW-1:0] pside;
		logic [VW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign pv    = ctl.vld;
			assign prem  = VW'(dividend[DW-1:QW]);
			assign pdvs  = divisor;
			assign plow  = dividend[QW-1:0];
			assign pquo  = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign prem  = rem_s[j-1];
			assign pdvs  = dvs_s[j-1];
			assign plow  = low_s[j-1];
			assign pquo  = quo_s[j-1];
			assign pside = side_s[j-1];
		end

		assign trial = {prem, plow[QW-1]};
		assign take  = trial >= {1'b0, pdvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[j]  <= take ? VW'(trial - {1'b0, pdvs}) : trial[VW-1:0];
				dvs_s[j]  <= pdvs;
				low_s[j]  <= plow << 1;
				quo_s[j]  <= {pquo[QW-2:0], take};
				side_s[j] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quotient = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

// ===== sv/rdu_isqrt.sv =====
// Pipelined integer floor square root, one root bit per stage, with a side word.
module rdu_isqrt #(
	parameter int IW = 56,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rdu_pkg::pipe_ctl_t ctl,
	input  logic [IW-1:0]      radicand,
	input  logic [SW-1:0]      side_in,
	output logic               out_vld,
	output logic [IW/2-1:0]    root,
	output logic [SW-1:0]      side_out
);
	import rdu_pkg::*;

	localparam int RW = IW / 2;

	logic          vld_s  [RW];
	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [IW-1:0] rad_s  [RW];
	logic [SW-1:0] side_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic          pv;
		logic [RW+1:0] prem;
		logic [RW-1:0] proot;
		logic [IW-1:0] prad;
		logic [SW-1:0] pside;
		logic [RW+3:0] cur;
		logic [RW+3:0] trl;
		logic          take;

		if (j == 0) begin : g_first
			assign pv    = ctl.vld;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = radicand;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[j-1];
			assign prem  = rem_s[j-1];
			assign proot = root_s[j-1];
			assign prad  = rad_s[j-1];
			assign pside = side_s[j-1];
		end

		assign cur  = {prem, prad[IW-1:IW-2]};
		assign trl  = (RW+4)'({proot, 2'b01});
		assign take = cur >= trl;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[j]  <= take ? (RW+2)'(cur - trl) : (RW+2)'(cur);
				root_s[j] <= {proot[RW-2:0], take};
				rad_s[j]  <= prad << 2;
				side_s[j] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule

// ===== sv/refraction_direction_unit.sv =====
// Top level of the Snell refraction direction pipeline.
//
//   channel  | handshake                  | word
//   input    | in_valid, in_stall (out)   | dir_x/y/z, norm_x/y/z, index_from, index_to
//   output   | out_valid, out_stall (in)  | out_x/y/z, total_reflection
//
// One word enters every cycle while no stalled output word holds the pipeline.
// The depth is set by the index divider, two root extractors and the output dividers.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output word freezes the whole pipeline, and in_stall follows it.
module refraction_direction_unit #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COMP_WIDTH-1:0] dir_x,
	input  logic signed [COMP_WIDTH-1:0] dir_y,
	input  logic signed [COMP_WIDTH-1:0] dir_z,
	input  logic signed [COMP_WIDTH-1:0] norm_x,
	input  logic signed [COMP_WIDTH-1:0] norm_y,
	input  logic signed [COMP_WIDTH-1:0] norm_z,
	input  logic [rdu_pkg::IDX_W-1:0]    index_from,
	input  logic [rdu_pkg::IDX_W-1:0]    index_to,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COMP_WIDTH-1:0] out_x,
	output logic signed [COMP_WIDTH-1:0] out_y,
	output logic signed [COMP_WIDTH-1:0] out_z,
	output logic                         total_reflection
);
	import rdu_pkg::*;

	localparam int LSH = (COMP_WIDTH <= 22) ? 22 - COMP_WIDTH : 0;
	localparam int RSH = (COMP_WIDTH > 22) ? COMP_WIDTH - 22 : 0;
	localparam int NW = MAG_W + COMP_WIDTH - 1;
	localparam int QW = COMP_WIDTH - 1;
	localparam int UNIT = 1 << (COMP_WIDTH - 2);

	logic en;
	pipe_ctl_t ctl_eta, ctl_root, ctl_mag, ctl_norm;

	logic signed [COMP_WIDTH-1:0] dir_in [3];
	logic signed [COMP_WIDTH-1:0] nrm_in [3];
	logic signed [AW-1:0] a_in [3];
	logic signed [AW-1:0] n_in [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	eta_side_t es_s1;
	logic [IDX_W-1:0] n1_s1, n2_s1;

	logic eta_vld;
	logic [ETA_W-1:0] eta_q;
	eta_side_t es_d;

	logic [ETA_W-1:0] eta_c, eta_s2, eta_s3;
	logic signed [2*AW-1:0] p_c [3];
	logic signed [2*AW-1:0] p_s2 [3];
	logic signed [EA_W-1:0] ea_c [3];
	logic [2:0][EA_W-1:0] ea_s2, ea_s3, ea_s4, ea_s5, ea_s6, ea_s7, ea_s8;
	logic [2:0][AW-1:0] n_s2, n_s3, n_s4, n_s5, n_s6, n_s7;

	logic signed [26:0] c1_c, c1_s3;
	logic [28:0] eta2_c, eta2_s3, eta2_s4;
	logic signed [ETAC_W-1:0] omc_c, omc_s4;
	logic signed [ETAC_W-1:0] etac_c, etac_s4, etac_s5, etac_s6;
	logic signed [59:0] t_c, t_s5;
	logic signed [40:0] c2_c;
	logic tir_s6;
	logic [RAD1_W-1:0] rad_s6;

	logic root_vld;
	logic [ROOT1_W-1:0] root1;
	root_side_t rs_in, rs_d;

	logic signed [R_W-1:0] k_c, k_s7;
	logic tir_s7, tir_s8, tir_s9, tir_s10, tir_s11;
	logic signed [53:0] kn_c [3];
	logic signed [53:0] kn_s8 [3];
	logic signed [R_W-1:0] r_c [3];
	logic [2:0][R_W-1:0] r_s9, r_s10, r_s11;
	logic [MAGSQ_W-1:0] sq_c [3];
	logic [MAGSQ_W-1:0] sq_s10 [3];
	logic [MAGSQ_W-1:0] magsq_c, magsq_s11;
	logic zero_s11;

	logic mag_vld;
	logic [MAG_W-1:0] mag;
	mag_side_t ms_in, ms_d;

	logic [NW-1:0] num_c [3];
	logic [NW-1:0] num_s12 [3];
	logic [MAG_W-1:0] dvs_s12;
	lane_side_t ls_s12 [3];

	logic vld_l [3];
	logic [QW-1:0] q_l [3];
	lane_side_t ls_l [3];
	logic signed [COMP_WIDTH-1:0] res_c [3];

	assign en = !(vld_s13 && out_stall);
	assign in_stall = !en;

	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;
	assign nrm_in[0] = norm_x;
	assign nrm_in[1] = norm_y;
	assign nrm_in[2] = norm_z;

	always_comb begin
		logic signed [53:0] ext_a;
		logic signed [53:0] ext_n;
		for (int i = 0; i < 3; i++) begin
			ext_a = 54'(dir_in[i]);
			ext_n = 54'(nrm_in[i]);
			a_in[i] = AW'((ext_a <<< LSH) >>> RSH);
			n_in[i] = AW'((ext_n <<< LSH) >>> RSH);
		end
	end

	// Eta saturates when the quotient exceeds 16.0 or does not fit the divider.
	assign eta_c = (es_d.ovf || (eta_q > ETA_MAX)) ? ETA_MAX : eta_q;

	always_comb begin
		logic signed [47:0] eam;
		for (int i = 0; i < 3; i++) begin
			p_c[i] = $signed(es_d.a[i]) * $signed(es_d.n[i]);
			eam = $signed({1'b0, eta_c}) * $signed(es_d.a[i]);
			ea_c[i] = EA_W'(eam >>> IFRAC);
		end
	end

	always_comb begin
		logic signed [45:0] psum;
		logic [2*ETA_W-1:0] e2;
		psum = 46'(p_s2[0]) + 46'(p_s2[1]) + 46'(p_s2[2]);
		c1_c = 27'(psum >>> IFRAC);
		e2 = eta_s2 * eta_s2;
		eta2_c = 29'(e2 >> IFRAC);
	end

	always_comb begin
		logic signed [53:0] c1sq;
		logic signed [53:0] omc_w;
		logic signed [52:0] ec;
		c1sq = c1_s3 * c1_s3;
		omc_w = 54'(IONE) - (c1sq >>> IFRAC);
		omc_c = ETAC_W'(omc_w);
		ec = $signed({1'b0, eta_s3}) * c1_s3;
		etac_c = ETAC_W'(ec >>> IFRAC);
	end

	assign t_c = $signed({1'b0, eta2_s4}) * omc_s4;
	assign c2_c = 41'(IONE) - 41'(t_s5 >>> IFRAC);

	assign rs_in.etac = etac_s6;
	assign rs_in.n = n_s6;
	assign rs_in.ea = ea_s6;
	assign rs_in.tir = tir_s6;

	assign k_c = 32'($signed(rs_d.etac)) - $signed({4'b0000, root1});

	always_comb begin
		logic signed [53:0] diff;
		logic signed [2*R_W-1:0] sqf;
		for (int i = 0; i < 3; i++) begin
			kn_c[i] = k_s7 * $signed(n_s7[i]);
			diff = (kn_s8[i] >>> IFRAC) - 54'($signed(ea_s8[i]));
			r_c[i] = R_W'(diff);
			sqf = $signed(r_s9[i]) * $signed(r_s9[i]);
			sq_c[i] = MAGSQ_W'(sqf);
		end
	end

	assign magsq_c = sq_s10[0] + sq_s10[1] + sq_s10[2];

	assign ms_in.r = r_s11;
	assign ms_in.zero = zero_s11;
	assign ms_in.tir = tir_s11;

	always_comb begin
		logic signed [R_W-1:0] rv;
		logic [MAG_W-1:0] m;
		for (int i = 0; i < 3; i++) begin
			rv = $signed(ms_d.r[i]);
			m = MAG_W'(rv[R_W-1] ? -rv : rv);
			num_c[i] = (NW'(m) << (COMP_WIDTH - 2)) + NW'(mag >> 1);
		end
	end

	always_comb begin
		logic signed [COMP_WIDTH-1:0] qv;
		for (int i = 0; i < 3; i++) begin
			qv = $signed({1'b0, q_l[i]});
			res_c[i] = ls_l[i].zero ? '0 : (ls_l[i].neg ? -qv : qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= eta_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= root_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= mag_vld;
			vld_s13 <= vld_l[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				es_s1.a[i] <= a_in[i];
				es_s1.n[i] <= n_in[i];
				p_s2[i] <= p_c[i];
				ea_s2[i] <= ea_c[i];
				kn_s8[i] <= kn_c[i];
				r_s9[i] <= r_c[i];
				sq_s10[i] <= sq_c[i];
				num_s12[i] <= num_c[i];
				ls_s12[i].neg <= ms_d.r[i][R_W-1];
				ls_s12[i].zero <= ms_d.zero;
				ls_s12[i].tir <= ms_d.tir;
			end
			es_s1.ovf <= (index_from >> 5) >= index_to;
			n1_s1 <= index_from;
			n2_s1 <= index_to;
			eta_s2 <= eta_c;
			n_s2 <= es_d.n;
			c1_s3 <= c1_c;
			eta2_s3 <= eta2_c;
			eta_s3 <= eta_s2;
			n_s3 <= n_s2;
			ea_s3 <= ea_s2;
			omc_s4 <= omc_c;
			etac_s4 <= etac_c;
			eta2_s4 <= eta2_s3;
			n_s4 <= n_s3;
			ea_s4 <= ea_s3;
			t_s5 <= t_c;
			etac_s5 <= etac_s4;
			n_s5 <= n_s4;
			ea_s5 <= ea_s4;
			tir_s6 <= c2_c[40];
			rad_s6 <= c2_c[40] ? '0 : {c2_c[35:0], 20'd0};
			etac_s6 <= etac_s5;
			n_s6 <= n_s5;
			ea_s6 <= ea_s5;
			k_s7 <= k_c;
			n_s7 <= rs_d.n;
			ea_s7 <= rs_d.ea;
			tir_s7 <= rs_d.tir;
			ea_s8 <= ea_s7;
			tir_s8 <= tir_s7;
			tir_s9 <= tir_s8;
			r_s10 <= r_s9;
			tir_s10 <= tir_s9;
			magsq_s11 <= magsq_c;
			r_s11 <= r_s10;
			zero_s11 <= tir_s10 || (magsq_c == '0);
			tir_s11 <= tir_s10;
			dvs_s12 <= ms_d.zero ? MAG_W'(1) : mag;
			out_x <= res_c[0];
			out_y <= res_c[1];
			out_z <= res_c[2];
			total_reflection <= ls_l[0].tir;
		end
	end

	assign ctl_eta  = '{en: en, vld: vld_s1};
	assign ctl_root = '{en: en, vld: vld_s6};
	assign ctl_mag  = '{en: en, vld: vld_s11};
	assign ctl_norm = '{en: en, vld: vld_s12};

	rdu_div #(
		.DW(IDX_W + IFRAC),
		.VW(IDX_W),
		.QW(ETA_W),
		.SW($bits(eta_side_t))
	) u_eta_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_eta),
		.dividend({n1_s1, 20'd0}),
		.divisor(n2_s1),
		.side_in(es_s1),
		.out_vld(eta_vld),
		.quotient(eta_q),
		.side_out(es_d)
	);

	rdu_isqrt #(
		.IW(RAD1_W),
		.SW($bits(root_side_t))
	) u_root_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_root),
		.radicand(rad_s6),
		.side_in(rs_in),
		.out_vld(root_vld),
		.root(root1),
		.side_out(rs_d)
	);

	rdu_isqrt #(
		.IW(MAGSQ_W),
		.SW($bits(mag_side_t))
	) u_mag_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_mag),
		.radicand(magsq_s11),
		.side_in(ms_in),
		.out_vld(mag_vld),
		.root(mag),
		.side_out(ms_d)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rdu_div #(
			.DW(NW),
			.VW(MAG_W),
			.QW(QW),
			.SW($bits(lane_side_t))
		) u_norm_div (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl_norm),
			.dividend(num_s12[i]),
			.divisor(dvs_s12),
			.side_in(ls_s12[i]),
			.out_vld(vld_l[i]),
			.quotient(q_l[i]),
			.side_out(ls_l[i])
		);
	end

	assign out_valid = vld_s13;

`ifndef SYNTHESIS
	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_reflection |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("total reflection word carries a nonzero vector");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output word");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_x <= UNIT && out_x >= -UNIT && out_y <= UNIT && out_y >= -UNIT
			&& out_z <= UNIT && out_z >= -UNIT)
		else $error("normalized component exceeds unit length");

	a_lane_align: assert property (@(posedge clk) disable iff (!arst_n)
		vld_l[1] == vld_l[0] && vld_l[2] == vld_l[0])
		else $error("output divider lanes out of step");
`endif

endmodule

// ===== bench/refraction_direction_unit_tb.sv =====
// Self-checking testbench for the Snell refraction direction pipeline.
`timescale 1ns / 100ps

module refraction_direction_unit_tb;

	localparam int CW = 16;
	localparam int LATENCY = 96 + CW;
	localparam int FRAC = 20;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint ETA_CAP = longint'(16) << FRAC;

	typedef struct {
		logic signed [CW-1:0] dx, dy, dz, nx, ny, nz;
		logic [15:0] n1, n2;
	} ray_t;

	typedef struct packed {
		logic signed [CW-1:0] x, y, z;
		logic tir;
	} refr_t;

	typedef struct {
		ray_t ray;
		bit typed;
		refr_t res;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [CW-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic [15:0] index_from = 16'd8192, index_to = 16'd8192;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] out_x, out_y, out_z;
	logic total_reflection;

	refr_t expected_dirs[$];
	int errors = 0;
	int n_sent = 0, n_seen = 0, n_tir = 0;
	int src_idle = 0, snk_stall = 0;
	bit hold_sink = 1'b0;
	vec_row_t vec_rows[$];

	refraction_direction_unit #(.COMP_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.index_from(index_from), .index_to(index_to),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.total_reflection(total_reflection)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] clamp_comp(longint v);
		longint hi, lo;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi[CW-1:0];
		if (v < lo)
			return lo[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic refr_t refract(ray_t t);
		refr_t o;
		longint a[3], n[3], r[3];
		longint c1, omc, eta, eta2, c2sq, root, k;
		longint unsigned e, magsq, mag, m, q;
		a[0] = longint'(t.dx) <<< (FRAC - (CW - 2));
		a[1] = longint'(t.dy) <<< (FRAC - (CW - 2));
		a[2] = longint'(t.dz) <<< (FRAC - (CW - 2));
		n[0] = longint'(t.nx) <<< (FRAC - (CW - 2));
		n[1] = longint'(t.ny) <<< (FRAC - (CW - 2));
		n[2] = longint'(t.nz) <<< (FRAC - (CW - 2));
		if (t.n2 == 0) begin
			eta = ETA_CAP;
		end else begin
			e = (longint'(t.n1) << FRAC) / longint'(t.n2);
			eta = (e > ETA_CAP) ? ETA_CAP : longint'(e);
		end
		c1 = floor_shr(a[0] * n[0] + a[1] * n[1] + a[2] * n[2], FRAC);
		omc = ONE - floor_shr(c1 * c1, FRAC);
		eta2 = floor_shr(eta * eta, FRAC);
		c2sq = ONE - floor_shr(eta2 * omc, FRAC);
		o.tir = 1'b0;
		if (c2sq < 0) begin
			o.x = '0;
			o.y = '0;
			o.z = '0;
			o.tir = 1'b1;
			return o;
		end
		root = longint'(int_sqrt(longint'(c2sq) << FRAC));
		k = floor_shr(eta * c1, FRAC) - root;
		magsq = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = floor_shr(k * n[i], FRAC) - floor_shr(eta * a[i], FRAC);
			magsq += longint'(r[i] * r[i]);
		end
		if (magsq == 0) begin
			o.x = clamp_comp(r[0]);
			o.y = clamp_comp(r[1]);
			o.z = clamp_comp(r[2]);
			return o;
		end
		mag = int_sqrt(magsq);
		for (int i = 0; i < 3; i++) begin
			m = (r[i] < 0) ? longint'(-r[i]) : longint'(r[i]);
			q = ((m << (CW - 2)) + mag / 2) / mag;
			r[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
		end
		o.x = clamp_comp(r[0]);
		o.y = clamp_comp(r[1]);
		o.z = clamp_comp(r[2]);
		return o;
	endfunction

	function automatic ray_t mk_ray(int dx, int dy, int dz, int nx, int ny, int nz,
			int n1, int n2);
		ray_t t;
		t.dx = dx[CW-1:0];
		t.dy = dy[CW-1:0];
		t.dz = dz[CW-1:0];
		t.nx = nx[CW-1:0];
		t.ny = ny[CW-1:0];
		t.nz = nz[CW-1:0];
		t.n1 = n1[15:0];
		t.n2 = n2[15:0];
		return t;
	endfunction

	function automatic ray_t random_ray();
		ray_t t;
		int ang, mode;
		mode = $urandom_range(0, 9);
		t.dx = CW'($urandom);
		t.dy = CW'($urandom);
		t.dz = CW'($urandom);
		t.nx = CW'($urandom);
		t.ny = CW'($urandom);
		t.nz = CW'($urandom);
		t.n1 = 16'($urandom_range(4096, 65535));
		t.n2 = 16'($urandom_range(4096, 65535));
		if (mode < 7) begin
			// Near-unit vectors with one dominant axis and realistic indices.
			ang = $urandom_range(0, 16383);
			t.dx = CW'($signed(ang) - 8192);
			t.dy = CW'($signed($urandom_range(0, 8191)) - 4096);
			t.dz = CW'(15000 - ($urandom_range(0, 1) * 30000));
			t.nx = CW'($signed($urandom_range(0, 4095)) - 2048);
			t.ny = CW'($signed($urandom_range(0, 4095)) - 2048);
			t.nz = CW'(16384);
			t.n1 = 16'($urandom_range(8192, 20000));
			t.n2 = 16'($urandom_range(8192, 20000));
		end else if (mode == 7) begin
			t.n2 = 16'($urandom_range(0, 4095));
		end
		return t;
	endfunction

	task automatic send_ray(ray_t t, bit typed, refr_t res);
		refr_t pred;
		while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		dir_x <= t.dx;
		dir_y <= t.dy;
		dir_z <= t.dz;
		norm_x <= t.nx;
		norm_y <= t.ny;
		norm_z <= t.nz;
		index_from <= t.n1;
		index_to <= t.n2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = refract(t);
		if (typed && res != pred) begin
			$display("%0t: table row expected x=%0d y=%0d z=%0d tir=%0b", $time,
				res.x, res.y, res.z, res.tir);
			$display("%0t:   predictor gives  x=%0d y=%0d z=%0d tir=%0b", $time,
				pred.x, pred.y, pred.z, pred.tir);
			errors++;
		end
		expected_dirs.push_back(typed ? res : pred);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_dirs.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_sink)
			out_stall <= 1'b1;
		else
			out_stall <= (snk_stall != 0) && ($urandom_range(0, 99) < snk_stall);
	end

	always @(posedge clk) begin
		refr_t exp_dir;
		if (arst_n && out_valid && !out_stall) begin
			n_seen++;
			if (total_reflection)
				n_tir++;
			if (expected_dirs.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d z=%0d tir=%0b", $time,
					out_x, out_y, out_z, total_reflection);
				errors++;
			end else begin
				exp_dir = expected_dirs.pop_front();
				if (out_x !== exp_dir.x || out_y !== exp_dir.y || out_z !== exp_dir.z
						|| total_reflection !== exp_dir.tir) begin
					$display("%0t: mismatch expected x=%0d y=%0d z=%0d tir=%0b",
						$time, exp_dir.x, exp_dir.y, exp_dir.z, exp_dir.tir);
					$display("%0t:          actual   x=%0d y=%0d z=%0d tir=%0b",
						$time, out_x, out_y, out_z, total_reflection);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("refraction_direction_unit regression: fail");
		$finish;
	end

	initial begin
		refr_t zero_r, tir_r, none_r;
		zero_r = '{x: '0, y: '0, z: '0, tir: 1'b0};
		tir_r = '{x: '0, y: '0, z: '0, tir: 1'b1};
		none_r = zero_r;
		vec_rows.push_back('{mk_ray(0, 0, 16384, 0, 0, 16384, 8192, 8192), 1'b1,
			'{x: '0, y: '0, z: -16384, tir: 1'b0}});
		vec_rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0, 8192, 8192), 1'b1, zero_r});
		vec_rows.push_back('{mk_ray(16384, 0, 0, 0, 0, 16384, 16384, 8192), 1'b1, tir_r});
		vec_rows.push_back('{mk_ray(16384, 0, 0, 0, 0, 16384, 65535, 0), 1'b1, tir_r});
		vec_rows.push_back('{mk_ray(11585, 0, 11585, 0, 0, 16384, 12288, 8192), 0, none_r});
		vec_rows.push_back('{mk_ray(11585, 0, 11585, 0, 0, 16384, 8192, 12288), 0, none_r});
		vec_rows.push_back('{mk_ray(0, 16384, 0, 0, 16384, 0, 4096, 65535), 0, none_r});
		vec_rows.push_back('{mk_ray(-32768, -32768, -32768, -32768, -32768, -32768,
			65535, 65535), 0, none_r});
		vec_rows.push_back('{mk_ray(32767, 32767, 32767, 32767, 32767, 32767,
			4096, 4096), 0, none_r});
		vec_rows.push_back('{mk_ray(32767, -32768, 0, -32768, 32767, 0, 65535, 4096),
			0, none_r});
		vec_rows.push_back('{mk_ray(0, 0, 16384, 0, 0, -16384, 8192, 8192), 0, none_r});
		vec_rows.push_back('{mk_ray(16384, 0, 0, 0, 16384, 0, 8192, 8192), 0, none_r});
		vec_rows.push_back('{mk_ray(9459, 9459, 9459, 0, 16384, 0, 10923, 8192),
			0, none_r});
		vec_rows.push_back('{mk_ray(-1, -1, -1, 1, 1, 1, 0, 0), 0, none_r});
		vec_rows.push_back('{mk_ray(0, 0, 16384, 16384, 0, 0, 12000, 0), 0, none_r});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (vec_rows[i])
			send_ray(vec_rows[i].ray, vec_rows[i].typed, vec_rows[i].res);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 69; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 69; end
				3: begin src_idle = 37; snk_stall = 37; end
				default: begin src_idle = 0; snk_stall = 0; end
			endcase
			if (ph == 4) begin
				fork
					begin
						hold_sink = 1'b1;
						repeat (3 * LATENCY) @(negedge clk);
						hold_sink = 1'b0;
					end
					for (int i = 0; i < 190; i++)
						send_ray(random_ray(), 1'b0, none_r);
				join
			end else begin
				for (int i = 0; i < 190; i++)
					send_ray(random_ray(), 1'b0, none_r);
			end
			drain();
		end

		drain();
		repeat (LATENCY + 20) @(negedge clk);
		$display("Covered %0d rays, %0d results checked, %0d with total reflection,",
			n_sent, n_seen, n_tir);
		$display("over idle and stall phases and one long output hold-off.");
		if (errors == 0 && expected_dirs.size() == 0)
			$display("refraction_direction_unit regression: pass");
		else
			$display("refraction_direction_unit regression: fail");
		$finish;
	end

endmodule
